### hw/rtl/olir_pkg.sv
`default_nettype none

package olir_pkg;

  localparam int VAL_W       = 32;
  localparam int POS_W       = 8;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 7;

  // operation codes carried on kind
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // result codes carried on status
  localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_REMOVED  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_READ     = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_INS_SHIFT = 6'b000010,
    S_INS_PUT   = 6'b000100,
    S_REM_SCAN  = 6'b001000,
    S_REM_SHIFT = 6'b010000,
    S_RD_WAIT   = 6'b100000
  } olir_state_t;

endpackage

`default_nettype wire

### hw/rtl/olir_mem.sv
`default_nettype none

module olir_mem #(
  parameter int  DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [olir_pkg::VAL_W-1:0] wr_data,
  input  wire logic                      rd_en,
  input  wire logic [AW-1:0]             rd_addr,
  output      logic [olir_pkg::VAL_W-1:0] rd_data
);
  import olir_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ordered_list_insert_remove.sv
// Append, failed insert, failed read and remove on an empty list answer straight from idle; a read
//   waits in S_RD_WAIT for the memory. Insert at p moves each entry from the tail down to p up one slot,
//   then writes the value. Remove scans from the front: a tail match is dropped, else later entries shift
//   down; a miss scans every entry. One operation at a time; busy is high while it runs.
// Cost is set by the single read and single write port of the entry memory: one entry moves per cycle.
// Reset (rst, synchronous) empties the list; the entry memory is not cleared. The receiver cannot stall.
`default_nettype none

module ordered_list_insert_remove #(
  parameter int CAPACITY = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output      logic                                  busy,
  input  wire logic [olir_pkg::KIND_W-1:0]           kind,
  input  wire logic signed [olir_pkg::POS_W-1:0]     position,
  input  wire logic signed [olir_pkg::VAL_W-1:0]     value,
  output      logic                                  done,
  output      logic [olir_pkg::STATUS_W-1:0]         status,
  output      logic signed [olir_pkg::VAL_W-1:0]     read_value,
  output      logic [olir_pkg::COUNT_OUT_W-1:0]      entry_count
);
  import olir_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  // width wide enough for both a non-negative position and the count
  localparam int PW = (CW > POS_W - 1) ? CW : POS_W - 1;

  olir_state_t      state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [AW-1:0]    rd_addr, rd_addr_next;   // address of the read now in flight
  logic [AW-1:0]    at_idx, at_idx_next;     // insert slot
  logic [VAL_W-1:0] op_value, op_value_next;
  logic             done_next;
  logic [STATUS_W-1:0] status_next;
  logic [VAL_W-1:0] rvalue, rvalue_next;
  logic [CW-1:0]    ecount, ecount_next;

  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  logic [VAL_W-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  logic [VAL_W-1:0] mem_rd_data;

  logic pos_ok;
  logic is_full;
  logic rd_last;

  olir_mem #(.DEPTH(CAPACITY)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // position names a held entry: non-negative and below the count
  assign pos_ok  = !position[POS_W-1] && (PW'(position[POS_W-2:0]) < PW'(count));
  assign is_full = (count == CW'(CAPACITY));
  // the entry in flight is the last one held
  assign rd_last = ((CW'(rd_addr) + CW'(1)) == count);

  always_comb begin
    state_next    = state;
    count_next    = count;
    rd_addr_next  = rd_addr;
    at_idx_next   = at_idx;
    op_value_next = op_value;
    done_next     = 1'b0;
    status_next   = status;
    rvalue_next   = rvalue;
    ecount_next   = ecount;

    mem_wr_en   = 1'b0;
    mem_wr_addr = rd_addr + AW'(1);
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = rd_addr;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_value_next = value;
          rvalue_next   = '0;
          priority if (kind == KIND_INSERT) begin
            if (is_full) begin
              // drop the beat, list unchanged
              done_next   = 1'b1;
              status_next = STAT_FULL;
              ecount_next = count;
            end else if (!pos_ok) begin
              // append straight into the slot past the tail
              mem_wr_en   = 1'b1;
              mem_wr_addr = AW'(count);
              mem_wr_data = value;
              count_next  = count + CW'(1);
              done_next   = 1'b1;
              status_next = STAT_INSERTED;
              ecount_next = count + CW'(1);
            end else begin
              // open a gap: move entries up starting from the tail
              at_idx_next  = AW'(position[POS_W-2:0]);
              mem_rd_en    = 1'b1;
              mem_rd_addr  = AW'(count - CW'(1));
              rd_addr_next = AW'(count - CW'(1));
              state_next   = S_INS_SHIFT;
            end
          end else if (kind == KIND_REMOVE) begin
            if (count == '0) begin
              done_next   = 1'b1;
              status_next = STAT_NOTFOUND;
              ecount_next = count;
            end else begin
              // scan from the front
              mem_rd_en    = 1'b1;
              mem_rd_addr  = '0;
              rd_addr_next = '0;
              state_next   = S_REM_SCAN;
            end
          end else if (kind == KIND_READ) begin
            if (pos_ok) begin
              mem_rd_en    = 1'b1;
              mem_rd_addr  = AW'(position[POS_W-2:0]);
              state_next   = S_RD_WAIT;
            end else begin
              done_next   = 1'b1;
              status_next = STAT_NOTFOUND;
              ecount_next = count;
            end
          end else begin
            // unused kind: nothing changes
            done_next   = 1'b1;
            status_next = STAT_NOTFOUND;
            ecount_next = count;
          end
        end
      end

      S_INS_SHIFT: begin
        // move the entry just read one slot up
        mem_wr_en   = 1'b1;
        mem_wr_addr = rd_addr + AW'(1);
        mem_wr_data = mem_rd_data;
        if (rd_addr == at_idx) begin
          state_next = S_INS_PUT;
        end else begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = rd_addr - AW'(1);
          rd_addr_next = rd_addr - AW'(1);
        end
      end

      S_INS_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = at_idx;
        mem_wr_data = op_value;
        count_next  = count + CW'(1);
        done_next   = 1'b1;
        status_next = STAT_INSERTED;
        ecount_next = count + CW'(1);
        state_next  = S_IDLE;
      end

      S_REM_SCAN: begin
        if (mem_rd_data == op_value) begin
          if (rd_last) begin
            // match on the tail: just drop it
            count_next  = count - CW'(1);
            done_next   = 1'b1;
            status_next = STAT_REMOVED;
            ecount_next = count - CW'(1);
            state_next  = S_IDLE;
          end else begin
            mem_rd_en    = 1'b1;
            mem_rd_addr  = rd_addr + AW'(1);
            rd_addr_next = rd_addr + AW'(1);
            state_next   = S_REM_SHIFT;
          end
        end else if (rd_last) begin
          done_next   = 1'b1;
          status_next = STAT_NOTFOUND;
          ecount_next = count;
          state_next  = S_IDLE;
        end else begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = rd_addr + AW'(1);
          rd_addr_next = rd_addr + AW'(1);
        end
      end

      S_REM_SHIFT: begin
        // close the gap: move the entry just read one slot down
        mem_wr_en   = 1'b1;
        mem_wr_addr = rd_addr - AW'(1);
        mem_wr_data = mem_rd_data;
        if (rd_last) begin
          count_next  = count - CW'(1);
          done_next   = 1'b1;
          status_next = STAT_REMOVED;
          ecount_next = count - CW'(1);
          state_next  = S_IDLE;
        end else begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = rd_addr + AW'(1);
          rd_addr_next = rd_addr + AW'(1);
        end
      end

      S_RD_WAIT: begin
        done_next   = 1'b1;
        status_next = STAT_READ;
        rvalue_next = mem_rd_data;
        ecount_next = count;
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    rd_addr  <= rd_addr_next;
    at_idx   <= at_idx_next;
    op_value <= op_value_next;
    status   <= status_next;
    rvalue   <= rvalue_next;
    ecount   <= ecount_next;
  end

  assign busy        = (state != S_IDLE);
  assign read_value  = rvalue;
  assign entry_count = COUNT_OUT_W'(ecount);

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  import olir_pkg::*;

  localparam int DEPTH = 64;
  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_PER_PHASE = 400;

  // kind 3 is not an operation; the block must answer not found
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // one result beat as the block reports it
  typedef struct packed {
    logic [STATUS_W-1:0]         st;
    logic signed [VAL_W-1:0]     rd;
    logic [COUNT_OUT_W-1:0]      cnt;
  } list_result_t;

  // one row of the directed table; typed rows carry their answer
  typedef struct packed {
    logic [KIND_W-1:0]           k;
    logic signed [POS_W-1:0]     p;
    logic signed [VAL_W-1:0]     v;
    logic                        typed;
    logic [STATUS_W-1:0]         st;
    logic signed [VAL_W-1:0]     rd;
    logic [COUNT_OUT_W-1:0]      cnt;
  } list_row_t;

  localparam int N_ROWS = 21;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [KIND_W-1:0] kind = '0;
  logic signed [POS_W-1:0] position = '0;
  logic signed [VAL_W-1:0] value = '0;

  wire logic busy;
  wire logic done;
  wire logic [STATUS_W-1:0] status;
  wire logic signed [VAL_W-1:0] read_value;
  wire logic [COUNT_OUT_W-1:0] entry_count;

  // shadow copy of the list, advanced at every accepted beat
  logic signed [VAL_W-1:0] shadow_list [DEPTH];
  int shadow_count = 0;

  list_result_t pending_results [$];
  list_result_t oldest_result;
  list_row_t directed_rows [N_ROWS];

  int fails = 0;
  int cycles = 0;
  int idle_pct = 0;

  ordered_list_insert_remove #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .position(position),
    .value(value),
    .done(done),
    .status(status),
    .read_value(read_value),
    .entry_count(entry_count)
  );

  always #5 clk = ~clk;

  // Guard against a hung block: end the run as a failure at the limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t timeout after %0d cycles, %0d results outstanding", $time, cycles,
               pending_results.size());
      $display("ordered_list_insert_remove verification failed");
      $finish;
    end
  end

  // Apply one operation to the shadow list and return the result it must produce.
  task automatic apply_list_op(input logic [KIND_W-1:0] k, input logic signed [POS_W-1:0] p,
                               input logic signed [VAL_W-1:0] v, output list_result_t r);
    int pi;
    int at;
    int hit;
    begin
      pi = p;
      hit = -1;
      r.st = STAT_NOTFOUND;
      r.rd = '0;
      case (k)
        KIND_INSERT: begin
          if (shadow_count >= DEPTH) begin
            r.st = STAT_FULL;
          end else begin
            // out-of-range or negative position means append
            at = (pi < 0 || pi >= shadow_count) ? shadow_count : pi;
            for (int i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i-1];
            shadow_list[at] = v;
            shadow_count++;
            r.st = STAT_INSERTED;
          end
        end
        KIND_REMOVE: begin
          // first match from the front wins
          for (int i = 0; i < shadow_count; i++)
            if (hit < 0 && shadow_list[i] == v) hit = i;
          if (hit >= 0) begin
            for (int i = hit; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
            shadow_count--;
            r.st = STAT_REMOVED;
          end
        end
        KIND_READ: begin
          if (pi >= 0 && pi < shadow_count) begin
            r.rd = shadow_list[pi];
            r.st = STAT_READ;
          end
        end
        default: ;
      endcase
      r.cnt = shadow_count[COUNT_OUT_W-1:0];
    end
  endtask

  // Present one beat after a random hold-off, wait for the handshake, then
  // record what the block owes for it. A typed answer replaces the predicted one.
  task automatic send_beat(input logic [KIND_W-1:0] k, input logic signed [POS_W-1:0] p,
                           input logic signed [VAL_W-1:0] v, input logic typed,
                           input list_result_t want);
    list_result_t predicted;
    begin
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
      start <= 1'b1;
      kind <= k;
      position <= p;
      value <= v;
      @(posedge clk);
      // busy read here is its value before this edge
      while (busy) @(posedge clk);
      apply_list_op(k, p, v, predicted);
      pending_results.push_back(typed ? want : predicted);
    end
  endtask

  // Values: a small pool to force duplicates, the extremes, or anything.
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] pv;
    begin
      case ($urandom_range(7))
        0, 1: pv = VAL_W'($urandom_range(7));
        2: begin
          case ($urandom_range(3))
            0: pv = VAL_MAX;
            1: pv = VAL_MIN;
            2: pv = '0;
            default: pv = -32'sd1;
          endcase
        end
        default: pv = $urandom;
      endcase
      return pv;
    end
  endfunction

  // Random traffic in chunks that grow, shrink or churn the list so it
  // swings between empty and full.
  task automatic run_random(input int n);
    int mode;
    int r;
    logic [KIND_W-1:0] k;
    logic signed [POS_W-1:0] p;
    logic signed [VAL_W-1:0] v;
    begin
      mode = 0;
      for (int n_done = 0; n_done < n; n_done++) begin
        if (n_done % 100 == 0) mode = (n_done == 0) ? 0 : $urandom_range(2);
        r = $urandom_range(99);
        if (r < 2) begin
          k = KIND_UNUSED;
        end else begin
          case (mode)
            0: k = (r < 80) ? KIND_INSERT : (r < 90) ? KIND_READ : KIND_REMOVE;
            1: k = (r < 15) ? KIND_INSERT : (r < 70) ? KIND_REMOVE : KIND_READ;
            default: k = (r < 40) ? KIND_INSERT : (r < 70) ? KIND_REMOVE : KIND_READ;
          endcase
        end
        v = pick_value();
        p = POS_W'($urandom_range(255));
        case (k)
          KIND_INSERT: begin
            case ($urandom_range(9))
              0: p = -8'sd1;
              1: p = POS_W'(shadow_count);
              2: ;
              3: p = POS_W'(shadow_count + $urandom_range(3));
              default: p = POS_W'($urandom_range(shadow_count));
            endcase
          end
          KIND_REMOVE: begin
            // mostly hit a held entry so removals really shift the list
            if (shadow_count > 0 && $urandom_range(3) != 0)
              v = shadow_list[$urandom_range(shadow_count - 1)];
          end
          KIND_READ: begin
            if (shadow_count > 0 && $urandom_range(4) != 0)
              p = POS_W'($urandom_range(shadow_count - 1));
          end
          default: ;
        endcase
        send_beat(k, p, v, 1'b0, '0);
      end
    end
  endtask

  // Check every result beat against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: status %0d read_value %0d entry_count %0d",
                 $time, status, read_value, entry_count);
        fails = fails + 1;
      end else begin
        oldest_result = pending_results.pop_front();
        if (status !== oldest_result.st) begin
          $display("%0t status: expected %0d, got %0d", $time, oldest_result.st, status);
          fails = fails + 1;
        end
        if (read_value !== oldest_result.rd) begin
          $display("%0t read_value: expected %0d, got %0d", $time, oldest_result.rd,
                   read_value);
          fails = fails + 1;
        end
        if (entry_count !== oldest_result.cnt) begin
          $display("%0t entry_count: expected %0d, got %0d", $time, oldest_result.cnt,
                   entry_count);
          fails = fails + 1;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) shadow_list[i] = '0;

    // Directed table: empty-list errors, extremes, front/back/middle inserts,
    // out-of-range reads, removal hits and misses, the unused kind.
    directed_rows = '{
      '{KIND_READ,    8'sd0,    32'sd0,      1'b1, STAT_NOTFOUND, 32'sd0,  7'd0},
      '{KIND_REMOVE,  8'sd0,    32'sd5,      1'b1, STAT_NOTFOUND, 32'sd0,  7'd0},
      '{KIND_UNUSED,  8'sd0,    32'sd0,      1'b1, STAT_NOTFOUND, 32'sd0,  7'd0},
      '{KIND_INSERT,  8'sd10,   VAL_MAX,     1'b1, STAT_INSERTED, 32'sd0,  7'd1},
      '{KIND_INSERT,  -8'sd1,   VAL_MIN,     1'b1, STAT_INSERTED, 32'sd0,  7'd2},
      '{KIND_INSERT,  8'sd0,    32'sd0,      1'b1, STAT_INSERTED, 32'sd0,  7'd3},
      '{KIND_READ,    8'sd0,    32'sd0,      1'b1, STAT_READ,     32'sd0,  7'd3},
      '{KIND_READ,    8'sd2,    32'sd0,      1'b1, STAT_READ,     VAL_MIN, 7'd3},
      '{KIND_READ,    -8'sd128, 32'sd0,      1'b1, STAT_NOTFOUND, 32'sd0,  7'd3},
      '{KIND_READ,    8'sd127,  32'sd0,      1'b1, STAT_NOTFOUND, 32'sd0,  7'd3},
      '{KIND_READ,    8'sd3,    32'sd0,      1'b1, STAT_NOTFOUND, 32'sd0,  7'd3},
      '{KIND_INSERT,  8'sd1,    -32'sd1,     1'b1, STAT_INSERTED, 32'sd0,  7'd4},
      '{KIND_REMOVE,  8'sd0,    VAL_MAX,     1'b1, STAT_REMOVED,  32'sd0,  7'd3},
      '{KIND_REMOVE,  8'sd0,    32'sh12345,  1'b1, STAT_NOTFOUND, 32'sd0,  7'd3},
      '{KIND_INSERT,  8'sd64,   32'sh55aa,   1'b0, STAT_INSERTED, 32'sd0,  7'd0},
      '{KIND_REMOVE,  8'sd0,    32'sd0,      1'b1, STAT_REMOVED,  32'sd0,  7'd3},
      '{KIND_INSERT,  8'sd1,    32'sd0,      1'b0, STAT_INSERTED, 32'sd0,  7'd0},
      '{KIND_READ,    8'sd1,    32'sd0,      1'b0, STAT_READ,     32'sd0,  7'd0},
      '{KIND_UNUSED,  8'sd127,  -32'sd1,     1'b0, STAT_NOTFOUND, 32'sd0,  7'd0},
      '{KIND_REMOVE,  8'sd0,    32'sh55aa,   1'b0, STAT_REMOVED,  32'sd0,  7'd0},
      '{KIND_READ,    8'sd2,    32'sd0,      1'b0, STAT_READ,     32'sd0,  7'd0}
    };

    // Hold reset, then release it once.
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 32;
    for (int i = 0; i < N_ROWS; i++)
      send_beat(directed_rows[i].k, directed_rows[i].p, directed_rows[i].v,
                directed_rows[i].typed,
                '{directed_rows[i].st, directed_rows[i].rd, directed_rows[i].cnt});

    // Sender gaps light, then heavy, then none.
    run_random(RANDOM_PER_PHASE);
    idle_pct = 85;
    run_random(RANDOM_PER_PHASE);
    idle_pct = 0;
    run_random(RANDOM_PER_PHASE);

    // Drop start, drain outstanding results, then let a stray beat show up.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("ordered_list_insert_remove verification clean");
    end else begin
      $display("ordered_list_insert_remove verification failed");
    end
    $finish;
  end

endmodule
